// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// An implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/whc_pkg.sv =====
package whc_pkg;

    // Chunk identifiers as they read from four little-endian bytes.
    localparam logic [31:0] ID_RIFF = 32'h4646_4952;
    localparam logic [31:0] ID_WAVE = 32'h4556_4157;
    localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
    localparam logic [31:0] ID_DATA = 32'h6174_6164;

    localparam logic [15:0] BITS_REQUIRED = 16'd16;
    localparam logic [31:0] RIFF_EXTRA    = 32'd8;

    // Header byte positions at which a field is complete.
    localparam logic [5:0] POS_RIFF_END  = 6'd3;
    localparam logic [5:0] POS_LEN_END   = 6'd7;
    localparam logic [5:0] POS_WAVE_END  = 6'd11;
    localparam logic [5:0] POS_FMT_END   = 6'd15;
    localparam logic [5:0] POS_BITS_END  = 6'd35;
    localparam logic [5:0] POS_DID_END   = 6'd39;
    localparam logic [5:0] POS_HDR_END   = 6'd43;
    localparam logic [5:0] HEADER_BYTES  = 6'd44;

    // Configuration register map.
    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic        REG_FILE_LENGTH = 1'b0;

    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_TRUNC_HDR  = 4'd1,
        ST_BAD_RIFF   = 4'd2,
        ST_LEN_MISM   = 4'd3,
        ST_BAD_WAVE   = 4'd4,
        ST_BAD_FMT    = 4'd5,
        ST_NOT_16BIT  = 4'd6,
        ST_BAD_DATAID = 4'd7,
        ST_TRUNC_DATA = 4'd8
    } status_t;

    // Pending header error, the low bits of a status code; zero means none.
    localparam logic [2:0] PEND_NONE = 3'd0;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [7:0] sample_out;
        logic       sample_valid;
        status_t    status;
        logic       last_sample;
    } out_item_t;

    // What the parser hands to the result register for one item.
    typedef struct packed {
        logic      valid;
        out_item_t item;
    } parse_res_t;

endpackage

// ===== rtl/core/whc_cfg.sv =====
module whc_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [whc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output logic [31:0]                     file_length
);

    logic [31:0] file_length_reg;
    logic        reg_sel;

    // Register index is the word address.
    assign reg_sel = paddr[2];

    // Register write on the access phase.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_length_reg <= '0;
        end else if (psel && penable && pwrite && reg_sel == whc_pkg::REG_FILE_LENGTH) begin
            file_length_reg <= pwdata;
        end
    end

    // Read data; addresses beyond the map read as zero.
    always_comb begin
        prdata = '0;
        if (reg_sel == whc_pkg::REG_FILE_LENGTH) begin
            prdata = file_length_reg;
        end
    end

    assign pready      = 1'b1;
    assign file_length = file_length_reg;

endmodule

// ===== rtl/core/whc_conv.sv =====
module whc_conv (
    input  logic [15:0] sample_in,
    output logic [7:0]  sample_out
);

    localparam logic [16:0] FULL_SCALE = 17'h0FFFF;

    logic [23:0] prod;
    logic [7:0]  quot;
    logic [15:0] rem_lo;
    logic        adj;
    logic [7:0]  quot_fix;

    // Scale by 255 as a shift and subtract.
    assign prod = {sample_in, 8'h00} - {8'h00, sample_in};

    // Divide by 65535: take the top bits, then correct by one where the
    // remainder against 65535 (low bits plus quotient) reaches the divisor.
    assign quot     = prod[23:16];
    assign rem_lo   = prod[15:0];
    assign adj      = ({1'b0, rem_lo} + {9'b0, quot}) >= FULL_SCALE;
    assign quot_fix = quot + {7'b0, adj};

    // Adding 128 modulo 256 flips the top bit.
    assign sample_out = {~quot_fix[7], quot_fix[6:0]};

endmodule

// ===== rtl/core/whc_parse.sv =====
`include "assert_macros.svh"

module whc_parse (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                go,
    input  whc_pkg::in_item_t   item,
    input  logic [31:0]         file_length,
    output whc_pkg::parse_res_t res
);

    logic [5:0]  pos_reg,      pos_next;
    logic [31:0] shift_reg,    shift_next;
    logic [30:0] left_reg,     left_next;
    logic [7:0]  low_reg,      low_next;
    logic        phase_reg,    phase_next;
    logic        finished_reg, finished_next;
    logic [2:0]  pend_reg,     pend_next;

    logic [31:0] shift_cat;
    logic [2:0]  pend_new;
    logic [30:0] left_dec;
    logic [7:0]  conv_val;
    logic        chunk_end;

    assign shift_cat = {item.in_byte, shift_reg[31:8]};
    assign left_dec  = left_reg - 31'd1;
    assign chunk_end = (pos_reg == whc_pkg::POS_WAVE_END) ||
                       (pos_reg == whc_pkg::POS_BITS_END) ||
                       (pos_reg == whc_pkg::POS_HDR_END);

    whc_conv u_conv (
        .sample_in  ({item.in_byte, low_reg}),
        .sample_out (conv_val)
    );

    // Header checks, sample counting and result forming for one item.
    always_comb begin
        pos_next      = pos_reg;
        shift_next    = shift_reg;
        left_next     = left_reg;
        low_next      = low_reg;
        phase_next    = phase_reg;
        pend_next     = pend_reg;
        pend_new      = pend_reg;
        res           = '0;
        res.item.status = whc_pkg::ST_OK;

        if (go && !finished_reg) begin
            if (pos_reg < whc_pkg::HEADER_BYTES) begin
                shift_next = shift_cat;
                pos_next   = pos_reg + 6'd1;

                // Only the first failed check of the header is kept.
                if (pend_reg == whc_pkg::PEND_NONE) begin
                    priority if (pos_reg == whc_pkg::POS_RIFF_END &&
                                 shift_cat != whc_pkg::ID_RIFF) begin
                        pend_new = 3'(whc_pkg::ST_BAD_RIFF);
                    end else if (pos_reg == whc_pkg::POS_LEN_END &&
                                 shift_cat + whc_pkg::RIFF_EXTRA != file_length) begin
                        pend_new = 3'(whc_pkg::ST_LEN_MISM);
                    end else if (pos_reg == whc_pkg::POS_WAVE_END &&
                                 shift_cat != whc_pkg::ID_WAVE) begin
                        pend_new = 3'(whc_pkg::ST_BAD_WAVE);
                    end else if (pos_reg == whc_pkg::POS_FMT_END &&
                                 shift_cat != whc_pkg::ID_FMT) begin
                        pend_new = 3'(whc_pkg::ST_BAD_FMT);
                    end else if (pos_reg == whc_pkg::POS_BITS_END &&
                                 shift_cat[31:16] != whc_pkg::BITS_REQUIRED) begin
                        pend_new = 3'(whc_pkg::ST_NOT_16BIT);
                    end else if (pos_reg == whc_pkg::POS_DID_END &&
                                 shift_cat != whc_pkg::ID_DATA) begin
                        pend_new = 3'(whc_pkg::ST_BAD_DATAID);
                    end else if (pos_reg == whc_pkg::POS_HDR_END) begin
                        left_next = shift_cat[31:1];
                    end else begin
                        pend_new = pend_reg;
                    end
                end
                pend_next = pend_new;

                // A chunk with a failed check reports at its last byte.
                priority if (chunk_end && pend_new != whc_pkg::PEND_NONE) begin
                    res.valid            = 1'b1;
                    res.item.status      = whc_pkg::ST_OK == whc_pkg::ST_OK ?
                                           whc_pkg::status_t'({1'b0, pend_new}) :
                                           whc_pkg::ST_OK;
                    res.item.last_sample = 1'b1;
                end else if (pos_reg == whc_pkg::POS_HDR_END) begin
                    if (left_next == '0) begin
                        res.valid            = 1'b1;
                        res.item.last_sample = 1'b1;
                    end else if (item.end_of_stream) begin
                        res.valid            = 1'b1;
                        res.item.status      = whc_pkg::ST_TRUNC_DATA;
                        res.item.last_sample = 1'b1;
                    end
                end else if (item.end_of_stream) begin
                    res.valid            = 1'b1;
                    res.item.status      = whc_pkg::ST_TRUNC_HDR;
                    res.item.last_sample = 1'b1;
                end else begin
                    // An ordinary header byte gives no result.
                    res.valid = 1'b0;
                end
            end else if (!phase_reg) begin
                // Low byte of a sample.
                low_next   = item.in_byte;
                phase_next = 1'b1;
                if (item.end_of_stream) begin
                    res.valid            = 1'b1;
                    res.item.status      = whc_pkg::ST_TRUNC_DATA;
                    res.item.last_sample = 1'b1;
                end
            end else begin
                // High byte completes a sample.
                phase_next             = 1'b0;
                left_next              = left_dec;
                res.valid              = 1'b1;
                res.item.sample_out    = conv_val;
                res.item.sample_valid  = 1'b1;
                res.item.last_sample   = (left_dec == '0) || item.end_of_stream;
                if (left_dec != '0 && item.end_of_stream) begin
                    res.item.status = whc_pkg::ST_TRUNC_DATA;
                end
            end
        end

        finished_next = finished_reg || (res.valid && res.item.last_sample);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            shift_reg    <= '0;
            left_reg     <= '0;
            low_reg      <= '0;
            phase_reg    <= 1'b0;
            finished_reg <= 1'b0;
            pend_reg     <= whc_pkg::PEND_NONE;
        end else begin
            pos_reg      <= pos_next;
            shift_reg    <= shift_next;
            left_reg     <= left_next;
            low_reg      <= low_next;
            phase_reg    <= phase_next;
            finished_reg <= finished_next;
            pend_reg     <= pend_next;
        end
    end

    // Once stopped, the parser stays stopped and forms no result.
    `ASSERT_NEXT(a_finished_sticky, aclk, aresetn, finished_reg, finished_reg,
                 "parser left the stopped state")
    `ASSERT_IMPL(a_no_res_when_done, aclk, aresetn, finished_reg, !res.valid,
                 "result formed after the final result")
    // The data phase toggles only once the whole header has been taken.
    `ASSERT_IMPL(a_phase_in_data, aclk, aresetn, phase_reg,
                 pos_reg == whc_pkg::HEADER_BYTES, "sample phase set inside the header")

endmodule

// ===== rtl/core/wav_header_check_pcm16_to_u8.sv =====
// Checks a WAV file taken one byte per item and converts its 16-bit samples to
// unsigned 8-bit. One item is accepted in every cycle while the result channel
// does not stall, and its result, if it has one, is offered on the result
// channel once the item has passed through the input register and the result
// register; the header checks and the sample conversion sit in the short logic
// between those two registers. A header byte or a sample's low byte normally
// gives no result; a sample's high byte gives the converted sample. Errors and
// early end of stream give a single result marked last, after which further
// items are accepted and dropped until reset. file_length should be written
// before the first byte.
`include "assert_macros.svh"

module wav_header_check_pcm16_to_u8 (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  whc_pkg::in_item_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output whc_pkg::out_item_t             m_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [whc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    logic                in_vld_reg;
    whc_pkg::in_item_t   in_data_reg;
    logic                out_vld_reg;
    whc_pkg::out_item_t  out_data_reg;
    logic                advance;
    logic [31:0]         file_length;
    whc_pkg::parse_res_t res;

    whc_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .file_length (file_length)
    );

    // The buffered item moves on when the result register can take a result.
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    whc_parse u_parse (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .go          (advance),
        .item        (in_data_reg),
        .file_length (file_length),
        .res         (res)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= res.valid;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res.valid) begin
            out_data_reg <= res.item;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_data_reg;

    // Nothing follows the final result, and an empty sample field reads zero.
    `ASSERT_NEXT(a_quiet_after_last, aclk, aresetn,
                 m_valid && m_ready && m_data.last_sample, !m_valid,
                 "result after the final result")
    `ASSERT_IMPL(a_error_is_last, aclk, aresetn,
                 m_valid && m_data.status != whc_pkg::ST_OK, m_data.last_sample,
                 "error status on a result not marked last")
    `ASSERT_IMPL(a_empty_sample_zero, aclk, aresetn,
                 m_valid && !m_data.sample_valid, m_data.sample_out == 8'd0,
                 "sample field set without a sample")

endmodule
